// ===== rtl/nttt_pkg.sv =====
// shared types and constants of the next trigger tick time block
// no dependencies; used by every module of the block
package nttt_pkg;

  // field widths fixed by the interface
  localparam int TIME_BITS    = 63;
  localparam int PCNT_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int STAT_BITS    = 3;

  // number of period registers in the register file
  localparam int NUM_PREGS = 4;

  // parameter defaults
  localparam int MAX_PERIODS_DEF = 4;
  localparam int PERIOD_BITS_DEF = 16;

  // iteration counts of the shared shift units
  localparam int DIV_STEPS = TIME_BITS;
  localparam int MUL_STEPS = TIME_BITS;

  // saturation value of time and tick
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // result status codes
  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK            = 3'd0,
    STAT_ZERO_INTERVAL = 3'd1,
    STAT_NO_PERIOD     = 3'd2,
    STAT_BEFORE_START  = 3'd3,
    STAT_OVERFLOW      = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_TIME    = 3'd0,
    REG_TICK_INTERVAL = 3'd1,
    REG_PERIOD_COUNT  = 3'd2,
    REG_PERIOD_ZERO   = 3'd3,
    REG_PERIOD_ONE    = 3'd4,
    REG_PERIOD_TWO    = 3'd5,
    REG_PERIOD_THREE  = 3'd6
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEL,
    S_PREP,
    S_MUL,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic sel_step;
    logic prep;
    logic mul_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic early_err;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/nttt_ctrl.sv =====
// sequencing state machine of the next trigger tick time block
// depends on nttt_pkg; drives the datapath through dp_cmd_t
module nttt_ctrl #(
  parameter int MAX_PERIODS = nttt_pkg::MAX_PERIODS_DEF,
  parameter int LANE_W      = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nttt_pkg::dp_sts_t   sts,
  output nttt_pkg::dp_cmd_t   cmd,
  output logic [LANE_W-1:0]   sel_idx
);

  localparam int CNT_A = $clog2(nttt_pkg::DIV_STEPS);
  localparam int CNT_W = (CNT_A > LANE_W) ? CNT_A : LANE_W;

  nttt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nttt_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign sel_idx = cnt_r[LANE_W-1:0];

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      nttt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.early_err ? nttt_pkg::S_DONE : nttt_pkg::S_DIV;
        end
      end
      nttt_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(nttt_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = nttt_pkg::S_SEL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nttt_pkg::S_SEL: begin
        cmd.sel_step = 1'b1;
        if (cnt_r == CNT_W'(MAX_PERIODS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = nttt_pkg::S_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nttt_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = nttt_pkg::S_MUL;
      end
      nttt_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CNT_W'(nttt_pkg::MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = nttt_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nttt_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = nttt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = nttt_pkg::S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // an erroneous word skips straight to the result
  a_err_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nttt_pkg::S_IDLE && in_valid && sts.early_err)
      |=> state_r == nttt_pkg::S_DONE)
    else $error("error word did not go straight to result");

  // division counter stays within its step count
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nttt_pkg::S_DIV |-> cnt_r < CNT_W'(nttt_pkg::DIV_STEPS))
    else $error("division counter out of range");

  // a result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a waiting word");

endmodule

// ===== rtl/nttt_dp.sv =====
// datapath: bit-serial divider with period remainder lanes, minimum
// search and bit-serial multiplier; depends on nttt_pkg
module nttt_dp #(
  parameter int MAX_PERIODS = nttt_pkg::MAX_PERIODS_DEF,
  parameter int PERIOD_BITS = nttt_pkg::PERIOD_BITS_DEF,
  parameter int LANE_W      = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nttt_pkg::dp_cmd_t               cmd,
  output nttt_pkg::dp_sts_t               sts,
  input  logic [LANE_W-1:0]               sel_idx,
  input  logic [nttt_pkg::TIME_BITS-1:0]  start_time,
  input  logic [nttt_pkg::TIME_BITS-1:0]  tick_interval,
  input  logic [PERIOD_BITS-1:0]          lane_p [MAX_PERIODS],
  input  logic [MAX_PERIODS-1:0]          lane_act,
  input  logic [nttt_pkg::TIME_BITS-1:0]  in_now_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nttt_pkg::TIME_BITS-1:0]  out_next_time,
  output logic [nttt_pkg::TIME_BITS-1:0]  out_next_tick,
  output logic [nttt_pkg::STAT_BITS-1:0]  out_status
);

  localparam int TB = nttt_pkg::TIME_BITS;

  logic [TB-1:0]          rem_r;
  logic [TB-1:0]          q_r;
  logic [PERIOD_BITS-1:0] lane_r [MAX_PERIODS];
  logic [TB:0]            best_r;
  logic                   found_r;
  logic [TB-1:0]          acc_r;
  logic                   ovf_r;
  nttt_pkg::status_t      stat_r;

  logic                   out_valid_r;
  logic [TB-1:0]          out_time_r;
  logic [TB-1:0]          out_tick_r;
  nttt_pkg::status_t      out_stat_r;

  // early error checks, in priority order
  nttt_pkg::status_t early_code;
  always_comb begin
    if (tick_interval == '0) begin
      early_code = nttt_pkg::STAT_ZERO_INTERVAL;
    end else if (lane_act == '0) begin
      early_code = nttt_pkg::STAT_NO_PERIOD;
    end else if (in_now_time < start_time) begin
      early_code = nttt_pkg::STAT_BEFORE_START;
    end else begin
      early_code = nttt_pkg::STAT_OK;
    end
  end

  assign sts.early_err = (early_code != nttt_pkg::STAT_OK);
  assign sts.out_busy  = out_valid_r && out_stall;

  // restoring division step, one quotient bit per cycle
  logic [TB:0]   div_shl;
  logic [TB+1:0] div_trial;
  logic          qbit;
  logic [TB-1:0] rem_step;
  always_comb begin
    div_shl   = {rem_r, q_r[TB-1]};
    div_trial = {1'b0, div_shl} - {2'b00, tick_interval};
    qbit      = !div_trial[TB+1];
    rem_step  = qbit ? div_trial[TB-1:0] : div_shl[TB-1:0];
  end

  // period lanes follow the quotient bits to get quotient mod period
  logic [PERIOD_BITS-1:0] lane_step [MAX_PERIODS];
  logic [PERIOD_BITS:0]   lane_wide [MAX_PERIODS];
  always_comb begin
    for (int i = 0; i < MAX_PERIODS; i++) begin
      lane_wide[i] = {lane_r[i], qbit};
      if (lane_wide[i] >= {1'b0, lane_p[i]}) begin
        lane_step[i] = PERIOD_BITS'(lane_wide[i] - {1'b0, lane_p[i]});
      end else begin
        lane_step[i] = lane_wide[i][PERIOD_BITS-1:0];
      end
    end
  end

  // candidate tick of the selected lane: q + p - (q mod p)
  logic [PERIOD_BITS-1:0] sel_off;
  logic [TB:0]            sel_cand;
  logic                   sel_take;
  always_comb begin
    sel_off  = lane_p[sel_idx] - lane_r[sel_idx];
    sel_cand = {1'b0, q_r} + (TB+1)'(sel_off);
    sel_take = lane_act[sel_idx] && (!found_r || sel_cand < best_r);
  end

  // shift-and-add multiply step, most significant tick bit first
  logic [TB+1:0] mul_sum;
  always_comb begin
    mul_sum = {1'b0, acc_r, 1'b0} + {2'b00, (q_r[TB-1] ? tick_interval : '0)};
  end

  // result assembly with saturation
  logic [TB:0]       tsum;
  logic [TB-1:0]     res_time;
  logic [TB-1:0]     res_tick;
  nttt_pkg::status_t res_stat;
  always_comb begin
    tsum = {1'b0, start_time} + {1'b0, acc_r};
    if (stat_r != nttt_pkg::STAT_OK) begin
      res_time = '0;
      res_tick = '0;
      res_stat = stat_r;
    end else if (best_r[TB]) begin
      res_time = nttt_pkg::TIME_MAX;
      res_tick = nttt_pkg::TIME_MAX;
      res_stat = nttt_pkg::STAT_OVERFLOW;
    end else if (ovf_r || tsum[TB]) begin
      res_time = nttt_pkg::TIME_MAX;
      res_tick = best_r[TB-1:0];
      res_stat = nttt_pkg::STAT_OVERFLOW;
    end else begin
      res_time = tsum[TB-1:0];
      res_tick = best_r[TB-1:0];
      res_stat = nttt_pkg::STAT_OK;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r   <= '0;
      q_r     <= in_now_time - start_time;
      stat_r  <= early_code;
      found_r <= 1'b0;
      for (int i = 0; i < MAX_PERIODS; i++) begin
        lane_r[i] <= '0;
      end
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      q_r   <= {q_r[TB-2:0], qbit};
      for (int i = 0; i < MAX_PERIODS; i++) begin
        lane_r[i] <= lane_step[i];
      end
    end else if (cmd.sel_step) begin
      if (sel_take) begin
        best_r  <= sel_cand;
        found_r <= 1'b1;
      end
    end else if (cmd.prep) begin
      q_r   <= best_r[TB-1:0];
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.mul_step) begin
      q_r   <= {q_r[TB-2:0], 1'b0};
      acc_r <= mul_sum[TB-1:0];
      ovf_r <= ovf_r | (mul_sum[TB+1:TB] != 2'b00);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_time_r <= res_time;
      out_tick_r <= res_tick;
      out_stat_r <= res_stat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_time = out_time_r;
  assign out_next_tick = out_tick_r;
  assign out_status    = out_stat_r;

  // division remainder stays below the interval
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < tick_interval)
    else $error("division remainder not below interval");

  // error words carry zero time and tick
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == nttt_pkg::STAT_ZERO_INTERVAL ||
                     out_stat_r == nttt_pkg::STAT_NO_PERIOD ||
                     out_stat_r == nttt_pkg::STAT_BEFORE_START))
      |-> (out_time_r == '0 && out_tick_r == '0))
    else $error("error word with non-zero fields");

  // a tick overflow always saturates the time as well
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tick_r == nttt_pkg::TIME_MAX &&
     out_stat_r == nttt_pkg::STAT_OVERFLOW) |-> out_time_r == nttt_pkg::TIME_MAX)
    else $error("saturated tick without saturated time");

endmodule

// ===== rtl/next_trigger_tick_time.sv =====
// next trigger tick time: one result word per accepted input word
// an error word skips the division, search and multiply; the tick overflow
// case runs the full sequence
// a new word is taken only once the previous one is through the 63-step
// divider and the 63-step multiplier; input taken while a result waits
// reset: synchronous active-low rst_n clears control and all config registers
module next_trigger_tick_time #(
  parameter int MAX_PERIODS = nttt_pkg::MAX_PERIODS_DEF,
  parameter int PERIOD_BITS = nttt_pkg::PERIOD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [nttt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [nttt_pkg::TIME_BITS-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nttt_pkg::TIME_BITS-1:0]    in_now_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nttt_pkg::TIME_BITS-1:0]    out_next_time,
  output logic [nttt_pkg::TIME_BITS-1:0]    out_next_tick,
  output logic [nttt_pkg::STAT_BITS-1:0]    out_status
);

  localparam int LANE_W  = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int USE_LIM = (MAX_PERIODS < nttt_pkg::NUM_PREGS) ?
                           MAX_PERIODS : nttt_pkg::NUM_PREGS;

  logic [nttt_pkg::TIME_BITS-1:0] start_r;
  logic [nttt_pkg::TIME_BITS-1:0] interval_r;
  logic [nttt_pkg::PCNT_BITS-1:0] pcount_r;
  logic [PERIOD_BITS-1:0]         period_r [nttt_pkg::NUM_PREGS];

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      interval_r <= '0;
      pcount_r   <= '0;
      for (int i = 0; i < nttt_pkg::NUM_PREGS; i++) begin
        period_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nttt_pkg::REG_START_TIME:    start_r     <= cfg_wdata;
        nttt_pkg::REG_TICK_INTERVAL: interval_r  <= cfg_wdata;
        nttt_pkg::REG_PERIOD_COUNT:  pcount_r    <= cfg_wdata[nttt_pkg::PCNT_BITS-1:0];
        nttt_pkg::REG_PERIOD_ZERO:   period_r[0] <= cfg_wdata[PERIOD_BITS-1:0];
        nttt_pkg::REG_PERIOD_ONE:    period_r[1] <= cfg_wdata[PERIOD_BITS-1:0];
        nttt_pkg::REG_PERIOD_TWO:    period_r[2] <= cfg_wdata[PERIOD_BITS-1:0];
        nttt_pkg::REG_PERIOD_THREE:  period_r[3] <= cfg_wdata[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // number of period registers in use, clamped
  logic [nttt_pkg::PCNT_BITS-1:0] used;
  assign used = (pcount_r > nttt_pkg::PCNT_BITS'(USE_LIM)) ?
                nttt_pkg::PCNT_BITS'(USE_LIM) : pcount_r;

  // per-lane period and active flag
  logic [PERIOD_BITS-1:0] lane_p [MAX_PERIODS];
  logic [MAX_PERIODS-1:0] lane_act;

  for (genvar g = 0; g < MAX_PERIODS; g++) begin : g_lane
    if (g < nttt_pkg::NUM_PREGS) begin : g_reg
      assign lane_p[g] = period_r[g];
    end else begin : g_none
      assign lane_p[g] = '0;
    end
    assign lane_act[g] = ({1'b0, used} > (nttt_pkg::PCNT_BITS + 1)'(g)) &&
                         (lane_p[g] != '0);
  end

  nttt_pkg::dp_cmd_t   cmd;
  nttt_pkg::dp_sts_t   sts;
  logic [LANE_W-1:0]   sel_idx;

  nttt_ctrl #(
    .MAX_PERIODS (MAX_PERIODS),
    .LANE_W      (LANE_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .sel_idx  (sel_idx)
  );

  nttt_dp #(
    .MAX_PERIODS (MAX_PERIODS),
    .PERIOD_BITS (PERIOD_BITS),
    .LANE_W      (LANE_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .sel_idx       (sel_idx),
    .start_time    (start_r),
    .tick_interval (interval_r),
    .lane_p        (lane_p),
    .lane_act      (lane_act),
    .in_now_time   (in_now_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_time (out_next_time),
    .out_next_tick (out_next_tick),
    .out_status    (out_status)
  );

endmodule
